[rtl/rhr_pkg.sv]
// Package for the RGB hue rotation block: widths, register map and shared types.
// Depends on nothing; used by rgb_hue_rotate_top and the testbench.
`default_nettype none

package rhr_pkg;

   localparam int HUE_FRAC_BITS_DEF = 6;
   localparam int PIX_W             = 8;
   localparam int SHIFT_W           = 15;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [0:0] REG_HUE_SHIFT = 1'b0;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

   typedef struct packed {
      logic [PIX_W-1:0] mx;
      logic [PIX_W-1:0] mn;
      logic [PIX_W-1:0] diff;
      logic [PIX_W-1:0] alpha;
      logic             grey;
      chan_type         chan;
      logic             neg;
   } ctx_type;

endpackage

`default_nettype wire

[rtl/rgb_hue_rotate_top.sv]
// Top level of the RGB hue rotation block: a fully pipelined hue shift of RGBA pixels.
// Depends on rhr_pkg.
//
//   channel   ports                            handshake
//   request   req_red/green/blue/alpha_in      start high, busy low
//   response  rsp_red/green/blue/alpha_out     rsp_valid strobe, one cycle
//   config    psel, penable, pwrite, paddr...  APB write, pready always high
//
// A new word is taken in every cycle; busy never rises.
// Each word passes through a front stage, one stage for each two quotient bits of the
// hue divider, and six stages for hue wrap, sector, product and reciprocal scaling.
// With six fraction bits the divider has six stages. Reset clears the valid bits and
// the shift register.
`default_nettype none

module rgb_hue_rotate_top #(
   parameter int HUE_FRAC_BITS = rhr_pkg::HUE_FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_red_in,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_green_in,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_blue_in,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_alpha_in,
   output logic                             rsp_valid,
   output logic [rhr_pkg::PIX_W-1:0]        rsp_red_out,
   output logic [rhr_pkg::PIX_W-1:0]        rsp_green_out,
   output logic [rhr_pkg::PIX_W-1:0]        rsp_blue_out,
   output logic [rhr_pkg::PIX_W-1:0]        rsp_alpha_out,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [rhr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire  [rhr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rhr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import rhr_pkg::*;

   localparam int SECTOR = 60 << HUE_FRAC_BITS;
   localparam int TURN   = 360 << HUE_FRAC_BITS;
   localparam int QW     = $clog2(SECTOR + 1);
   localparam int NW     = QW + PIX_W;
   localparam int HW     = $clog2(TURN);
   localparam int DS     = (QW + 1) / 2;
   localparam int CTX_N  = DS + 6;
   localparam int XW     = 12;
   localparam int RECIP  = 17476;
   localparam int RSH    = 18;
   localparam int XMW    = XW + 15;

   function automatic logic [HW-1:0] shift_wrap(input logic [SHIFT_W-1:0] s);
      logic [31:0] v;
      v = 32'(s);
      for (int k = 7; k >= 0; k--) begin
         if ((TURN << k) < (1 << SHIFT_W)) begin
            if (v >= 32'(TURN << k)) begin
               v = v - 32'(TURN << k);
            end
         end
      end
      return HW'(v);
   endfunction

   logic [SHIFT_W-1:0] hue_shift_ff;
   logic [HW-1:0]      shift_mod_ff;
   logic               csr_wr;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_shift_ff <= '0;
         shift_mod_ff <= '0;
      end else begin
         if (csr_wr && paddr[2] == REG_HUE_SHIFT) begin
            hue_shift_ff <= pwdata[SHIFT_W-1:0];
         end
         shift_mod_ff <= shift_wrap(hue_shift_ff);
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_HUE_SHIFT) begin
         prdata = CSR_DATA_W'(hue_shift_ff);
      end
   end

   // Front stage: extremes, maximum channel and scaled numerator.
   ctx_type          ctx_ff [0:CTX_N-1];
   logic             vld_ff [0:CTX_N-1];
   ctx_type          ctx_in;
   logic [NW-1:0]    num_in;
   logic [PIX_W-1:0] ea, eb, mag, mx, mn;

   always_comb begin
      mx = req_red_in;
      mn = req_red_in;
      if (req_green_in > mx) mx = req_green_in;
      if (req_blue_in > mx) mx = req_blue_in;
      if (req_green_in < mn) mn = req_green_in;
      if (req_blue_in < mn) mn = req_blue_in;
      priority if (mx == req_red_in) begin
         ctx_in.chan = CH_RED;
         ea = req_green_in;
         eb = req_blue_in;
      end else if (mx == req_green_in) begin
         ctx_in.chan = CH_GREEN;
         ea = req_blue_in;
         eb = req_red_in;
      end else begin
         ctx_in.chan = CH_BLUE;
         ea = req_red_in;
         eb = req_green_in;
      end
      ctx_in.neg   = ea < eb;
      mag          = ctx_in.neg ? eb - ea : ea - eb;
      ctx_in.mx    = mx;
      ctx_in.mn    = mn;
      ctx_in.diff  = mx - mn;
      ctx_in.alpha = req_alpha_in;
      ctx_in.grey  = mx == mn;
      num_in       = NW'(NW'(mag) * NW'(60)) << HUE_FRAC_BITS;
   end

   logic [NW-1:0] rem_ff [0:DS];
   logic [QW-1:0] quo_ff [0:DS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CTX_N; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int i = 1; i < CTX_N; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[0] <= ctx_in;
      rem_ff[0] <= num_in;
      quo_ff[0] <= '0;
      for (int i = 1; i < CTX_N; i++) begin
         ctx_ff[i] <= ctx_ff[i-1];
      end
   end

   // Restoring divider, two quotient bits per stage.
   for (genvar k = 1; k <= DS; k++) begin : g_div
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      always_comb begin
         int j;
         rem_in = rem_ff[k-1];
         quo_in = quo_ff[k-1];
         for (int t = 0; t < 2; t++) begin
            j = QW - 1 - 2 * (k - 1) - t;
            if (j >= 0) begin
               if (rem_in >= (NW'(ctx_ff[k-1].diff) << j)) begin
                  rem_in    = rem_in - (NW'(ctx_ff[k-1].diff) << j);
                  quo_in[j] = 1'b1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         quo_ff[k] <= quo_in;
      end
   end

   // Hue in one turn, then shifted and wrapped.
   logic [HW:0]   hp_ff, hp_in, base;
   logic [HW+1:0] hs;
   logic [HW-1:0] h2_ff, h2_in;

   always_comb begin
      unique case (ctx_ff[DS].chan)
         CH_GREEN: base = (HW+1)'(2 * SECTOR);
         CH_BLUE:  base = (HW+1)'(4 * SECTOR);
         default:  base = '0;
      endcase
      if (ctx_ff[DS].neg) begin
         hp_in = base + (HW+1)'(TURN) - (HW+1)'(quo_ff[DS]);
      end else begin
         hp_in = base + (HW+1)'(quo_ff[DS]);
      end
      hs = (HW+2)'(hp_ff) + (HW+2)'(shift_mod_ff);
      priority if (hs >= (HW+2)'(2 * TURN)) begin
         h2_in = HW'(hs - (HW+2)'(2 * TURN));
      end else if (hs >= (HW+2)'(TURN)) begin
         h2_in = HW'(hs - (HW+2)'(TURN));
      end else begin
         h2_in = HW'(hs);
      end
   end

   // Sector, position, and product with the chroma.
   logic [2:0]    sec_in, sec_c_ff, sec_d_ff, sec_e_ff;
   logic [HW-1:0] frac;
   logic [QW-1:0] pos_in, pos_ff;
   logic [NW-1:0] prod_ff;
   logic [XW-1:0] x_in, x_ff;
   logic [XMW-1:0] xm_ff;

   always_comb begin
      sec_in = 3'd0;
      for (int s = 1; s < 6; s++) begin
         if (h2_ff >= HW'(s * SECTOR)) begin
            sec_in = 3'(s);
         end
      end
      frac   = h2_ff - HW'(HW'(sec_in) * HW'(SECTOR));
      pos_in = sec_in[0] ? QW'(SECTOR) - QW'(frac) : QW'(frac);
      x_in   = XW'(prod_ff >> (HUE_FRAC_BITS + 2));
   end

   always_ff @(posedge clock) begin
      hp_ff    <= hp_in;
      h2_ff    <= h2_in;
      sec_c_ff <= sec_in;
      pos_ff   <= pos_in;
      sec_d_ff <= sec_c_ff;
      prod_ff  <= NW'(ctx_ff[DS+3].diff) * NW'(pos_ff);
      sec_e_ff <= sec_d_ff;
      x_ff     <= x_in;
      xm_ff    <= XMW'(x_in) * XMW'(RECIP);
   end

   // Quotient by fifteen with one correction step, then the channel order.
   logic [PIX_W-1:0] q0, mid;
   logic [XW-1:0]    rr;
   logic [PIX_W-1:0] ro, go, bo;
   ctx_type          ce;

   always_comb begin
      ce  = ctx_ff[DS+5];
      q0  = PIX_W'(xm_ff >> RSH);
      rr  = x_ff - XW'(XW'(q0) * XW'(15));
      mid = ce.mn + q0 + PIX_W'(rr >= XW'(15));
      unique case (sec_e_ff)
         3'd0:    begin ro = ce.mx; go = mid;   bo = ce.mn; end
         3'd1:    begin ro = mid;   go = ce.mx; bo = ce.mn; end
         3'd2:    begin ro = ce.mn; go = ce.mx; bo = mid;   end
         3'd3:    begin ro = ce.mn; go = mid;   bo = ce.mx; end
         3'd4:    begin ro = mid;   go = ce.mn; bo = ce.mx; end
         default: begin ro = ce.mx; go = ce.mn; bo = mid;   end
      endcase
      if (ce.grey) begin
         ro = ce.mx;
         go = ce.mx;
         bo = ce.mx;
      end
   end

   logic rsp_valid_ff;
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff, alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[DS+5];
      end
      red_ff   <= ro;
      green_ff <= go;
      blue_ff  <= bo;
      alpha_ff <= ce.alpha;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_alpha_out = alpha_ff;

endmodule

`default_nettype wire

[tb/sv/rgb_hue_rotate_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the RGB hue rotation block: tracks the shift register from the
// configuration port, predicts each output pixel word and compares. Uses rhr_pkg.
module rgb_hue_rotate_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire                              busy,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_red_in,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_green_in,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_blue_in,
   input  wire  [rhr_pkg::PIX_W-1:0]        req_alpha_in,
   input  wire                              rsp_valid,
   input  wire  [rhr_pkg::PIX_W-1:0]        rsp_red_out,
   input  wire  [rhr_pkg::PIX_W-1:0]        rsp_green_out,
   input  wire  [rhr_pkg::PIX_W-1:0]        rsp_blue_out,
   input  wire  [rhr_pkg::PIX_W-1:0]        rsp_alpha_out,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire                              pready,
   input  wire  [rhr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire  [rhr_pkg::CSR_DATA_W-1:0]   pwdata,
   input  wire                              finish_check,
   output int                               pending,
   output int                               errors
);
   import rhr_pkg::*;

   localparam int SCALE  = 1 << HUE_FRAC_BITS_DEF;
   localparam int SECTOR = 60 * SCALE;
   localparam int TURN   = 360 * SCALE;

   typedef struct packed {
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] a;
   } pixel_type;

   pixel_type          rotated_q[$];
   logic [SHIFT_W-1:0] shift_reg;
   int                 mismatches;
   logic               leftover_done;

   function automatic int sector_offset(int x, int y, int diff);
      if (x >= y) begin
         return (SECTOR * (x - y)) / diff;
      end
      return -((SECTOR * (y - x)) / diff);
   endfunction

   function automatic pixel_type rotate_hue(pixel_type p, logic [SHIFT_W-1:0] shift);
      pixel_type o;
      int mx, mn, diff, h, h2, sector, frac, pos, mid, r, g, b;
      r = int'(p.r);
      g = int'(p.g);
      b = int'(p.b);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      diff = mx - mn;
      o = p;
      if (diff != 0) begin
         if (mx == r) h = sector_offset(g, b, diff);
         else if (mx == g) h = sector_offset(b, r, diff) + 2 * SECTOR;
         else h = sector_offset(r, g, diff) + 4 * SECTOR;
         if (h < 0) h += TURN;
         h2 = (h + (int'(shift) % TURN)) % TURN;
         sector = h2 / SECTOR;
         frac = h2 - sector * SECTOR;
         pos = sector[0] ? SECTOR - frac : frac;
         mid = mn + (diff * pos) / SECTOR;
         case (sector)
            0: begin mid = mid; {o.r, o.g, o.b} = {PIX_W'(mx), PIX_W'(mid), PIX_W'(mn)}; end
            1: begin {o.r, o.g, o.b} = {PIX_W'(mid), PIX_W'(mx), PIX_W'(mn)}; end
            2: begin {o.r, o.g, o.b} = {PIX_W'(mn), PIX_W'(mx), PIX_W'(mid)}; end
            3: begin {o.r, o.g, o.b} = {PIX_W'(mn), PIX_W'(mid), PIX_W'(mx)}; end
            4: begin {o.r, o.g, o.b} = {PIX_W'(mid), PIX_W'(mn), PIX_W'(mx)}; end
            default: begin {o.r, o.g, o.b} = {PIX_W'(mx), PIX_W'(mn), PIX_W'(mid)}; end
         endcase
      end
      return o;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rotated_q.delete();
         shift_reg <= '0;
         mismatches = 0;
         leftover_done <= 1'b0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_HUE_SHIFT) begin
            shift_reg <= pwdata[SHIFT_W-1:0];
         end
         if (rsp_valid) begin
            if (rotated_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected output word %h %h %h %h",
                  rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
            end else begin
               want = rotated_q.pop_front();
               if (want != {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out}) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch rgba: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                        want.r, want.g, want.b, want.a,
                        rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
                  end
               end
            end
         end
         if (start && !busy) begin
            rotated_q.push_back(rotate_hue({req_red_in, req_green_in, req_blue_in,
               req_alpha_in}, shift_reg));
         end
         if (finish_check && !leftover_done) begin
            mismatches += rotated_q.size();
            leftover_done <= 1'b1;
         end
      end
      pending <= rotated_q.size();
      errors <= mismatches;
   end

endmodule

[tb/sv/rgb_hue_rotate_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for rgb_hue_rotate_top: drives directed pixel words and random bursts across
// several shift settings and reports the verdict. Needs rhr_pkg and the checker.
module rgb_hue_rotate_top_tb;
   import rhr_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [PIX_W-1:0]      req_red_in, req_green_in, req_blue_in, req_alpha_in;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic                  psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;
   logic                  finish_check;
   int                    pending, errors, idle_cycles;

   localparam logic [CSR_ADDR_W-1:0] ADDR_HUE_SHIFT = CSR_ADDR_W'(REG_HUE_SHIFT) << 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;
   localparam int WATCHDOG_LIMIT = 2000;

   rgb_hue_rotate_top uut (.*);

   rgb_hue_rotate_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input logic [31:0] px);
      start <= 1'b1;
      {req_red_in, req_green_in, req_blue_in, req_alpha_in} <= px;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [31:0] random_pixel();
      logic [7:0] hi, lo, c[3];
      int k;
      k = $urandom_range(0, 9);
      hi = 8'($urandom);
      lo = 8'($urandom_range(0, hi));
      if (k == 0) begin
         c[0] = hi; c[1] = hi; c[2] = hi;
      end else if (k == 1) begin
         c[0] = hi; c[1] = hi; c[2] = lo;
      end else begin
         c[0] = 8'($urandom); c[1] = 8'($urandom); c[2] = 8'($urandom);
      end
      k = $urandom_range(0, 2);
      return {c[k], c[(k + 1) % 3], c[(k + 2) % 3], 8'($urandom)};
   endfunction

   task automatic run_directed();
      logic [31:0] words[20] = '{
         32'h000000ff, 32'hffffff00, 32'h80808055, 32'hff0000ff, 32'h00ff0000,
         32'h0000ffaa, 32'hffff0011, 32'h00ffff22, 32'hff00ff33, 32'h01000044,
         32'h00000166, 32'hfe00ff77, 32'h00feff88, 32'hfffe0099, 32'hff0001cc,
         32'h01ff00dd, 32'h7f8081ee, 32'hc0c0bf01, 32'hff00fe02, 32'h00010003
      };
      foreach (words[i]) send_word(words[i]);
   endtask

   task automatic run_random(input int count);
      int sent, burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            sent++;
            send_word(random_pixel());
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic [31:0] shifts[8] = '{32'h0000_59ff, 32'hffff_ffff, 32'h1, 32'd3840,
                                 32'd11520, 32'h0, 32'hdead_0000, 32'h0};
      reset <= 1'b1;
      start <= 1'b0;
      {req_red_in, req_green_in, req_blue_in, req_alpha_in} <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      finish_check <= 1'b0;
      shifts[7] = $urandom_range(0, 32767);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      foreach (shifts[i]) begin
         drain();
         csr_write(ADDR_HUE_SHIFT, shifts[i]);
         if (i % 3 == 0) begin
            @(posedge clock);
            csr_write(ADDR_UNMAPPED, $urandom);
         end
         run_directed();
         run_random(55);
      end
      drain();
      repeat (20) @(posedge clock);
      finish_check <= 1'b1;
      repeat (3) @(posedge clock);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
